// ===== design/per_routine_shadow_stack_checker_top_macros.svh =====
// Assertion macros for the shadow stack checker.
`ifndef PER_ROUTINE_SHADOW_STACK_CHECKER_TOP_MACROS_SVH
`define PER_ROUTINE_SHADOW_STACK_CHECKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shadow stack checker: same-cycle check failed");
`define SSC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shadow stack checker: next-cycle check failed");
`else
`define SSC_ASSERT_SAME(name, ante, cons)
`define SSC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== design/ssc_pkg.sv =====
// Shared types and constants for the shadow stack checker.
package ssc_pkg;

    localparam int ID_W         = 6;
    localparam int ADDR_W       = 64;
    localparam int IDX_W        = 32;
    localparam int OUT_DEPTH_W  = 5;

    localparam int NUM_ROUTINES_DEF = 64;
    localparam int STACK_DEPTH_DEF  = 16;

    typedef enum logic [2:0] {
        ST_PUSHED    = 3'd0,
        ST_RET_OK    = 3'd1,
        ST_NO_ENTRY  = 3'd2,
        ST_FRAME_BAD = 3'd3,
        ST_RET_BAD   = 3'd4,
        ST_OVERFLOW  = 3'd5,
        ST_HALTED    = 3'd6
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   routine_id;
        logic [ADDR_W-1:0] frame_base;
        logic [ADDR_W-1:0] ret_ip;
    } evt_t;

    typedef struct packed {
        status_t                status;
        logic [IDX_W-1:0]       entry_index;
        logic [OUT_DEPTH_W-1:0] stack_depth;
        logic [ADDR_W-1:0]      saved_frame;
        logic [ADDR_W-1:0]      saved_return;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    lookup;
        logic    calc_addr;
        logic    rd_entry;
        logic    push;
        logic    pop;
        logic    set_halt;
        logic    emit;
        logic    clr_step;
        status_t code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode;
        logic halted;
        logic full;
        logic empty;
        logic frame_eq;
        logic ret_eq;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/per_routine_shadow_stack_checker_top.sv =====
// Top level of the per-routine shadow stack checker.
//
//  channel | direction | handshake             | payload
//  evt     | in        | evt_valid / evt_ready | ssc_pkg::evt_t
//  res     | out       | res_valid / res_ready | ssc_pkg::res_t
//
// A call, a return to an empty stack or any event while halted passes through the lookup,
// address and access states from acceptance to the next acceptance; any other return, good
// or mismatched, also passes through a check state. The chain of lookup, address, store
// access and compare through the single-port depth table and entry stores sets this order.
// After reset the depth table is cleared one routine per cycle; evt_ready first rises once
// every routine has been cleared.
// A result waiting in the output register holds the next item in its final step only.
`include "per_routine_shadow_stack_checker_top_macros.svh"

module per_routine_shadow_stack_checker_top #(
    parameter int NUM_ROUTINES = ssc_pkg::NUM_ROUTINES_DEF,
    parameter int STACK_DEPTH  = ssc_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_ready,
    input  ssc_pkg::evt_t evt,
    output logic          res_valid,
    input  logic          res_ready,
    output ssc_pkg::res_t res
);

    ssc_pkg::cmd_t cmd;
    ssc_pkg::sts_t sts;

    ssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ssc_dp #(
        .NUM_ROUTINES (NUM_ROUTINES),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    `SSC_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free)
    `SSC_ASSERT_SAME(a_push_legal, cmd.push, !sts.full && !sts.halted)
    `SSC_ASSERT_SAME(a_pop_match, cmd.pop, sts.frame_eq && sts.ret_eq && !sts.halted)
    `SSC_ASSERT_NEXT(a_halt_sticks, cmd.set_halt, sts.halted)

endmodule

// ===== design/ssc_ctrl.sv =====
// Sequencing controller for the shadow stack checker.
module ssc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_ready,
    input  ssc_pkg::sts_t sts,
    output ssc_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_ADDR,
        S_ACCESS,
        S_CHECK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign evt_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ssc_pkg::ST_PUSHED;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                state_next    = S_ACCESS;
            end
            S_ACCESS:
            begin
                if (sts.halted)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ssc_pkg::ST_HALTED;
                        state_next = S_IDLE;
                    end
                end
                else if (!sts.mode)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit = 1'b1;
                        if (sts.full)
                        begin
                            cmd.code = ssc_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                            cmd.code = ssc_pkg::ST_PUSHED;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (sts.empty)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.set_halt = 1'b1;
                        cmd.code     = ssc_pkg::ST_NO_ENTRY;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // hold until the result register can take the item
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!sts.frame_eq)
                    begin
                        cmd.set_halt = 1'b1;
                        cmd.code     = ssc_pkg::ST_FRAME_BAD;
                    end
                    else if (!sts.ret_eq)
                    begin
                        cmd.set_halt = 1'b1;
                        cmd.code     = ssc_pkg::ST_RET_BAD;
                    end
                    else
                    begin
                        cmd.pop  = 1'b1;
                        cmd.code = ssc_pkg::ST_RET_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/ssc_dp.sv =====
// Datapath of the shadow stack checker: depth table, entry stores, result register.
module ssc_dp #(
    parameter int NUM_ROUTINES = ssc_pkg::NUM_ROUTINES_DEF,
    parameter int STACK_DEPTH  = ssc_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ssc_pkg::evt_t evt,
    input  ssc_pkg::cmd_t cmd,
    output ssc_pkg::sts_t sts,
    output logic          res_valid,
    input  logic          res_ready,
    output ssc_pkg::res_t res
);

    localparam int RID_W   = (NUM_ROUTINES > 1) ? $clog2(NUM_ROUTINES) : 1;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int SLOTS   = NUM_ROUTINES * STACK_DEPTH;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_IDS = 2 ** ssc_pkg::ID_W;

    logic [DEPTH_W-1:0]         depth_mem [NUM_ROUTINES];
    logic [ssc_pkg::ADDR_W-1:0] frame_mem [SLOTS];
    logic [ssc_pkg::ADDR_W-1:0] ret_mem   [SLOTS];
    logic [ssc_pkg::IDX_W-1:0]  idx_mem   [SLOTS];

    logic                       mode_reg;
    logic [RID_W-1:0]           rid_reg;
    logic [RID_W-1:0]           rid_next;
    logic [ssc_pkg::ADDR_W-1:0] frame_reg;
    logic [ssc_pkg::ADDR_W-1:0] ret_reg;
    logic [DEPTH_W-1:0]         depth_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic [SLOT_W-1:0]          slot_next;
    logic [DEPTH_W-1:0]         depth_sel;
    logic [ssc_pkg::ADDR_W-1:0] rd_frame_reg;
    logic [ssc_pkg::ADDR_W-1:0] rd_ret_reg;
    logic [ssc_pkg::IDX_W-1:0]  rd_idx_reg;
    logic [ssc_pkg::IDX_W-1:0]  seq_reg;
    logic                       halted_reg;
    logic [RID_W-1:0]           clr_idx_reg;
    ssc_pkg::res_t              res_reg;
    ssc_pkg::res_t              res_next;
    logic                       res_valid_reg;

    logic                       depth_we;
    logic [RID_W-1:0]           depth_waddr;
    logic [DEPTH_W-1:0]         depth_wdata;
    logic [DEPTH_W-1:0]         depth_inc;
    logic [DEPTH_W-1:0]         depth_dec;
    logic [DEPTH_W-1:0]         depth_out;
    logic [DEPTH_W+ssc_pkg::OUT_DEPTH_W-1:0] depth_ext;

    // Reduce the id modulo the routine count through a constant lookup
    always_comb
    begin
        rid_next = '0;
        for (int k = 0; k < NUM_IDS; k++)
        begin
            if (evt.routine_id == ssc_pkg::ID_W'(k))
            begin
                rid_next = RID_W'(k % NUM_ROUTINES);
            end
        end
    end

    assign depth_inc = depth_reg + DEPTH_W'(1);
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign depth_sel = mode_reg ? depth_dec : depth_reg;
    assign slot_next = SLOT_W'(rid_reg) * SLOT_W'(STACK_DEPTH) + SLOT_W'(depth_sel);

    // Input capture and slot address
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= evt.mode;
            rid_reg   <= rid_next;
            frame_reg <= evt.frame_base;
            ret_reg   <= evt.ret_ip;
        end
        if (cmd.calc_addr)
        begin
            slot_reg <= slot_next;
        end
    end

    // Depth table: clearing pass, push and pop share one write port
    assign depth_we    = cmd.clr_step | cmd.push | cmd.pop;
    assign depth_waddr = cmd.clr_step ? clr_idx_reg : rid_reg;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            depth_wdata = '0;
        end
        else if (cmd.push)
        begin
            depth_wdata = depth_inc;
        end
        else
        begin
            depth_wdata = depth_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[depth_waddr] <= depth_wdata;
        end
        if (cmd.lookup)
        begin
            depth_reg <= depth_mem[rid_reg];
        end
    end

    // Entry stores
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            frame_mem[slot_reg] <= frame_reg;
            ret_mem[slot_reg]   <= ret_reg;
            idx_mem[slot_reg]   <= seq_reg;
        end
        if (cmd.rd_entry)
        begin
            rd_frame_reg <= frame_mem[slot_reg];
            rd_ret_reg   <= ret_mem[slot_reg];
            rd_idx_reg   <= idx_mem[slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= '0;
            halted_reg  <= 1'b0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                seq_reg <= seq_reg + ssc_pkg::IDX_W'(1);
            end
            if (cmd.set_halt)
            begin
                halted_reg <= 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + RID_W'(1);
            end
        end
    end

    // Result formation
    always_comb
    begin
        res_next        = '0;
        res_next.status = cmd.code;
        depth_out       = depth_reg;
        case (cmd.code)
            ssc_pkg::ST_PUSHED:
            begin
                res_next.entry_index = seq_reg;
                depth_out            = depth_inc;
            end
            ssc_pkg::ST_RET_OK:
            begin
                res_next.entry_index  = rd_idx_reg;
                res_next.saved_frame  = rd_frame_reg;
                res_next.saved_return = rd_ret_reg;
                depth_out             = depth_dec;
            end
            ssc_pkg::ST_FRAME_BAD, ssc_pkg::ST_RET_BAD:
            begin
                res_next.entry_index  = rd_idx_reg;
                res_next.saved_frame  = rd_frame_reg;
                res_next.saved_return = rd_ret_reg;
            end
            default:
            begin
                depth_out = depth_reg;
            end
        endcase
        depth_ext            = {{ssc_pkg::OUT_DEPTH_W{1'b0}}, depth_out};
        res_next.stack_depth = depth_ext[ssc_pkg::OUT_DEPTH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign sts.mode     = mode_reg;
    assign sts.halted   = halted_reg;
    assign sts.full     = (depth_reg >= DEPTH_W'(STACK_DEPTH));
    assign sts.empty    = (depth_reg == '0);
    assign sts.frame_eq = (rd_frame_reg == frame_reg);
    assign sts.ret_eq   = (rd_ret_reg == ret_reg);
    assign sts.clr_last = (clr_idx_reg == RID_W'(NUM_ROUTINES - 1));
    assign sts.out_free = !res_valid_reg || res_ready;

endmodule

// ===== verif/tb_per_routine_shadow_stack_checker_top.sv =====
// Testbench for the per-routine shadow stack checker: predicted results checked item by item.
`timescale 1ns / 100ps

module tb_per_routine_shadow_stack_checker_top;

    localparam int ROUTINES     = ssc_pkg::NUM_ROUTINES_DEF;
    localparam int DEPTH_MAX    = ssc_pkg::STACK_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SEGMENTS     = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 200;

    logic          clk;
    logic          rst_n;
    logic          evt_valid;
    logic          evt_ready;
    ssc_pkg::evt_t evt;
    logic          res_valid;
    logic          res_ready;
    ssc_pkg::res_t res;

    per_routine_shadow_stack_checker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Shadow copy of the per-routine stacks
    logic [ssc_pkg::ADDR_W-1:0] shadow_frame [ROUTINES][DEPTH_MAX];
    logic [ssc_pkg::ADDR_W-1:0] shadow_ret   [ROUTINES][DEPTH_MAX];
    logic [ssc_pkg::IDX_W-1:0]  shadow_idx   [ROUTINES][DEPTH_MAX];
    int                         shadow_depth [ROUTINES];
    logic [ssc_pkg::IDX_W-1:0]  shadow_seq;
    bit                         shadow_halted;

    ssc_pkg::res_t pending_res[$];
    int   err_cnt     = 0;
    int   report_cnt  = 0;
    int   idle_cycles = 0;
    bit   no_idle     = 1'b0;
    bit   hold_req    = 1'b0;
    int   last_rid    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ssc_pkg::res_t predict_shadow(ssc_pkg::evt_t e);
        ssc_pkg::res_t r;
        int   rid;
        int   d;
        int   top;
        rid = int'(e.routine_id) % ROUTINES;
        d = shadow_depth[rid];
        r = '0;
        r.stack_depth = ssc_pkg::OUT_DEPTH_W'(d);
        if (shadow_halted)
        begin
            r.status = ssc_pkg::ST_HALTED;
            return r;
        end
        if (e.mode == 1'b0)
        begin
            if (d >= DEPTH_MAX)
            begin
                r.status = ssc_pkg::ST_OVERFLOW;
                return r;
            end
            shadow_frame[rid][d] = e.frame_base;
            shadow_ret[rid][d]   = e.ret_ip;
            shadow_idx[rid][d]   = shadow_seq;
            shadow_depth[rid]    = d + 1;
            r.status      = ssc_pkg::ST_PUSHED;
            r.entry_index = shadow_seq;
            r.stack_depth = ssc_pkg::OUT_DEPTH_W'(d + 1);
            shadow_seq    = shadow_seq + 1'b1;
            return r;
        end
        if (d == 0)
        begin
            shadow_halted = 1'b1;
            r.status = ssc_pkg::ST_NO_ENTRY;
            return r;
        end
        top = d - 1;
        r.entry_index  = shadow_idx[rid][top];
        r.saved_frame  = shadow_frame[rid][top];
        r.saved_return = shadow_ret[rid][top];
        if (shadow_frame[rid][top] != e.frame_base)
        begin
            shadow_halted = 1'b1;
            r.status = ssc_pkg::ST_FRAME_BAD;
        end
        else if (shadow_ret[rid][top] != e.ret_ip)
        begin
            shadow_halted = 1'b1;
            r.status = ssc_pkg::ST_RET_BAD;
        end
        else
        begin
            shadow_depth[rid] = top;
            r.status      = ssc_pkg::ST_RET_OK;
            r.stack_depth = ssc_pkg::OUT_DEPTH_W'(top);
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ssc_pkg::ADDR_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic ssc_pkg::evt_t make_evt(logic m, int rid,
                                               logic [ssc_pkg::ADDR_W-1:0] fb,
                                               logic [ssc_pkg::ADDR_W-1:0] ra);
        ssc_pkg::evt_t e;
        e.mode       = m;
        e.routine_id = ssc_pkg::ID_W'(rid);
        e.frame_base = fb;
        e.ret_ip     = ra;
        return e;
    endfunction

    // Calls on random or hot routines; returns that match the top entry
    function automatic ssc_pkg::evt_t next_wellformed(int call_pct);
        ssc_pkg::evt_t e;
        int   rid;
        int   k;
        int   start;
        rid = -1;
        if ($urandom_range(1, 100) > call_pct)
        begin
            if (shadow_depth[last_rid] > 0 && $urandom_range(0, 9) < 6)
                rid = last_rid;
            else
            begin
                start = $urandom_range(0, ROUTINES - 1);
                for (k = 0; k < ROUTINES && rid < 0; k++)
                    if (shadow_depth[(start + k) % ROUTINES] > 0)
                        rid = (start + k) % ROUTINES;
            end
        end
        if (rid >= 0)
            e = make_evt(1'b1, rid, shadow_frame[rid][shadow_depth[rid] - 1],
                         shadow_ret[rid][shadow_depth[rid] - 1]);
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
                rid = last_rid;
            else if (k < 55)
                rid = $urandom_range(0, 3);
            else
                rid = $urandom_range(0, ROUTINES - 1);
            e = make_evt(1'b0, rid, rand_word(), rand_word());
        end
        last_rid = rid;
        return e;
    endfunction

    task automatic send_evt(input ssc_pkg::evt_t e);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            evt_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt = e;
        evt_valid = 1'b1;
        do @(posedge clk); while (!evt_ready);
        pending_res.push_back(predict_shadow(e));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (report_cnt < MAX_REPORTS)
            begin
                report_cnt++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        end
    endtask

    task automatic test_extremes();
        send_evt(make_evt(1'b0, 0, '0, '0));
        send_evt(make_evt(1'b0, ROUTINES - 1, '1, '1));
        send_evt(make_evt(1'b0, 42, {16{4'ha}}, {16{4'h5}}));
        send_evt(make_evt(1'b0, 21, {16{4'h5}}, {16{4'ha}}));
        send_evt(make_evt(1'b1, 21, {16{4'h5}}, {16{4'ha}}));
        send_evt(make_evt(1'b1, 42, {16{4'ha}}, {16{4'h5}}));
        send_evt(make_evt(1'b1, ROUTINES - 1, '1, '1));
        send_evt(make_evt(1'b1, 0, '0, '0));
    endtask

    // Fill one routine, push past the top, then pop once from full
    task automatic test_overflow();
        int rid;
        rid = $urandom_range(0, ROUTINES - 1);
        repeat (DEPTH_MAX) send_evt(make_evt(1'b0, rid, rand_word(), rand_word()));
        repeat (2) send_evt(make_evt(1'b0, rid, rand_word(), rand_word()));
        send_evt(make_evt(1'b1, rid, shadow_frame[rid][DEPTH_MAX - 1],
                          shadow_ret[rid][DEPTH_MAX - 1]));
        last_rid = rid;
    endtask

    task automatic test_random();
        int seg;
        int n;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            no_idle = (seg == 2);
            for (n = 0; n < RANDOM_ITEMS / SEGMENTS; n++)
                send_evt(next_wellformed((seg % 2 == 0) ? 65 : 40));
        end
        no_idle = 1'b0;
    endtask

    // Hold the result side off while items keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (40) send_evt(next_wellformed(55));
        no_idle = 1'b0;
    endtask

    // One failing return, then events that must all report halted
    task automatic test_halt();
        int                         kind;
        int                         rid;
        int                         k;
        logic [ssc_pkg::ADDR_W-1:0] mask;
        ssc_pkg::evt_t              e;
        kind = $urandom_range(0, 2);
        rid = -1;
        if (kind == 0)
        begin
            for (k = 0; k < ROUTINES && rid < 0; k++)
                if (shadow_depth[k] == 0)
                    rid = k;
            if (rid < 0)
                kind = 1;
        end
        if (kind != 0)
        begin
            rid = last_rid;
            if (shadow_depth[rid] == 0)
                send_evt(make_evt(1'b0, rid, rand_word(), rand_word()));
        end
        if ($urandom_range(0, 1) == 0)
            mask = 64'd1 << $urandom_range(0, ssc_pkg::ADDR_W - 1);
        else
            mask = {$urandom, $urandom} | 64'd1;
        if (kind == 0)
            e = make_evt(1'b1, rid, rand_word(), rand_word());
        else
        begin
            e = make_evt(1'b1, rid, shadow_frame[rid][shadow_depth[rid] - 1],
                         shadow_ret[rid][shadow_depth[rid] - 1]);
            if (kind == 1)
                e.frame_base = e.frame_base ^ mask;
            else
                e.ret_ip = e.ret_ip ^ mask;
        end
        send_evt(e);
        repeat (12)
            send_evt(make_evt(1'($urandom_range(0, 1)), $urandom_range(0, ROUTINES - 1),
                              rand_word(), rand_word()));
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        stall = 0;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else if (stall == 0 && !no_idle && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                res_ready = 1'b0;
                stall--;
            end
            else
                res_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ssc_pkg::res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_res.size() == 0)
            begin
                err_cnt++;
                if (report_cnt < MAX_REPORTS)
                begin
                    report_cnt++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, res);
                end
            end
            else
            begin
                want = pending_res.pop_front();
                check_field("status", 64'(want.status), 64'(res.status));
                check_field("entry_index", 64'(want.entry_index), 64'(res.entry_index));
                check_field("stack_depth", 64'(want.stack_depth), 64'(res.stack_depth));
                check_field("saved_frame", want.saved_frame, res.saved_frame);
                check_field("saved_return", want.saved_return, res.saved_return);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_per_routine_shadow_stack_checker_top failed");
            $finish;
        end
    end

    initial
    begin
        int k;
        int wait_cnt;
        rst_n = 1'b0;
        evt_valid = 1'b0;
        evt = '0;
        for (k = 0; k < ROUTINES; k++)
            shadow_depth[k] = 0;
        shadow_seq = '0;
        shadow_halted = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_overflow();
        test_random();
        test_backpressure();
        test_halt();

        @(negedge clk);
        evt_valid = 1'b0;
        wait_cnt = 0;
        while (pending_res.size() != 0 && wait_cnt < IDLE_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && pending_res.size() == 0)
            $display("tb_per_routine_shadow_stack_checker_top passed");
        else
            $display("tb_per_routine_shadow_stack_checker_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ssc_pkg.sv
design/ssc_ctrl.sv
design/ssc_dp.sv
design/per_routine_shadow_stack_checker_top.sv
verif/tb_per_routine_shadow_stack_checker_top.sv
